FILE: hdl/bdl_pkg.sv
package bdl_pkg;

   // field widths
   localparam int BOND_W   = 16;
   localparam int STRAIN_W = 16;
   localparam int LEN_W    = 16;

   // datapath widths
   localparam int PROD_W = 2 * BOND_W;          // bi*bj
   localparam int TERM_W = PROD_W + STRAIN_W;   // Eij*bi*bj
   localparam int BB_W   = PROD_W + 2;          // bx^2+by^2+bz^2
   localparam int SUM_W  = TERM_W + 2;          // three terms
   localparam int Q_W    = 53;                  // full quadratic form, signed
   localparam int Q_DROP = 11;                  // low bits dropped before the root
   localparam int RAD_W  = 40;                  // radicand, Q < 2^51
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;
   localparam int SQRT_STEPS = ROOT_W;

   // output queue
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // register map
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_STRAIN_XX = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_STRAIN_YY = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_STRAIN_ZZ = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_STRAIN_YZ = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_STRAIN_XZ = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_STRAIN_XY = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PLANAR    = 3'd6;

   typedef struct packed {
      logic signed [STRAIN_W-1:0] xx;
      logic signed [STRAIN_W-1:0] yy;
      logic signed [STRAIN_W-1:0] zz;
      logic signed [STRAIN_W-1:0] yz;
      logic signed [STRAIN_W-1:0] xz;
      logic signed [STRAIN_W-1:0] xy;
   } bdl_strain_type;

   // one slot of the square-root chain
   typedef struct packed {
      logic              valid;
      logic              invalid;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } bdl_cell_type;

   typedef struct packed {
      logic [LEN_W-1:0] deformed_length;
      logic             invalid;
   } bdl_rsp_type;

endpackage

FILE: hdl/bdl_req_if.sv
interface bdl_req_if import bdl_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic signed [BOND_W-1:0] bond_x;
   logic signed [BOND_W-1:0] bond_y;
   logic signed [BOND_W-1:0] bond_z;

   modport source (output valid, output bond_x, output bond_y, output bond_z, input ready);
   modport sink   (input valid, input bond_x, input bond_y, input bond_z, output ready);
endinterface

FILE: hdl/bdl_rsp_if.sv
interface bdl_rsp_if import bdl_pkg::*;;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] deformed_length;
   logic             invalid;

   modport source (output valid, output deformed_length, output invalid, input ready);
   modport sink   (input valid, input deformed_length, input invalid, output ready);
endinterface

FILE: hdl/bdl_front.sv
module bdl_front import bdl_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [BOND_W-1:0] bond_x,
   input  logic signed [BOND_W-1:0] bond_y,
   input  logic signed [BOND_W-1:0] bond_z,
   input  bdl_strain_type           strain,
   output bdl_cell_type             cell_out
);

   // stage A: capture the beat
   logic                     v_a_ff, v_a_in;
   logic signed [BOND_W-1:0] bx_ff, by_ff, bz_ff;

   // stage B: component products
   logic                     v_b_ff, v_b_in;
   logic signed [PROD_W-1:0] p_xx_ff, p_yy_ff, p_zz_ff, p_xy_ff, p_xz_ff, p_yz_ff;
   logic signed [PROD_W-1:0] p_xx_in, p_yy_in, p_zz_in, p_xy_in, p_xz_in, p_yz_in;

   // stage C: strain terms and squared norm
   logic                     v_c_ff, v_c_in;
   logic signed [TERM_W-1:0] t_xx_ff, t_yy_ff, t_zz_ff, t_xy_ff, t_xz_ff, t_yz_ff;
   logic signed [TERM_W-1:0] t_xx_in, t_yy_in, t_zz_in, t_xy_in, t_xz_in, t_yz_in;
   logic signed [BB_W-1:0]   bb_c_ff, bb_c_in;

   // stage D: partial sums
   logic                     v_d_ff, v_d_in;
   logic signed [SUM_W-1:0]  s_diag_ff, s_diag_in, s_off_ff, s_off_in;
   logic signed [BB_W-1:0]   bb_d_ff;

   // stage E: quadratic form
   logic signed [Q_W-1:0]    q;
   logic                     q_pos;
   bdl_cell_type             cell_ff, cell_in;

   assign v_a_in = in_valid;
   assign v_b_in = v_a_ff;
   assign v_c_in = v_b_ff;
   assign v_d_in = v_c_ff;

   always_comb begin
      p_xx_in = bx_ff * bx_ff;
      p_yy_in = by_ff * by_ff;
      p_zz_in = bz_ff * bz_ff;
      p_xy_in = bx_ff * by_ff;
      p_xz_in = bx_ff * bz_ff;
      p_yz_in = by_ff * bz_ff;
   end

   always_comb begin
      t_xx_in = $signed(strain.xx) * p_xx_ff;
      t_yy_in = $signed(strain.yy) * p_yy_ff;
      t_zz_in = $signed(strain.zz) * p_zz_ff;
      t_xy_in = $signed(strain.xy) * p_xy_ff;
      t_xz_in = $signed(strain.xz) * p_xz_ff;
      t_yz_in = $signed(strain.yz) * p_yz_ff;
      bb_c_in = BB_W'(p_xx_ff) + BB_W'(p_yy_ff) + BB_W'(p_zz_ff);
   end

   always_comb begin
      s_diag_in = SUM_W'(t_xx_ff) + SUM_W'(t_yy_ff) + SUM_W'(t_zz_ff);
      s_off_in  = SUM_W'(t_xy_ff) + SUM_W'(t_xz_ff) + SUM_W'(t_yz_ff);
   end

   // Q = 8192*|b|^2 + 2*diag + 4*off; a non-positive form enters the root as zero
   always_comb begin
      q = (Q_W'(bb_d_ff) <<< 13) + (Q_W'(s_diag_ff) <<< 1) + (Q_W'(s_off_ff) <<< 2);
      q_pos = !q[Q_W-1] && (q != '0);
      cell_in.valid   = v_d_ff;
      cell_in.invalid = !q_pos;
      cell_in.rad     = q_pos ? q[Q_DROP+RAD_W-1:Q_DROP] : '0;
      cell_in.rem     = '0;
      cell_in.root    = '0;
   end

   // control and the slot handed to the root chain
   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff  <= 1'b0;
         v_b_ff  <= 1'b0;
         v_c_ff  <= 1'b0;
         v_d_ff  <= 1'b0;
         cell_ff <= '0;
      end else begin
         v_a_ff  <= v_a_in;
         v_b_ff  <= v_b_in;
         v_c_ff  <= v_c_in;
         v_d_ff  <= v_d_in;
         cell_ff <= cell_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      bx_ff     <= bond_x;
      by_ff     <= bond_y;
      bz_ff     <= bond_z;
      p_xx_ff   <= p_xx_in;
      p_yy_ff   <= p_yy_in;
      p_zz_ff   <= p_zz_in;
      p_xy_ff   <= p_xy_in;
      p_xz_ff   <= p_xz_in;
      p_yz_ff   <= p_yz_in;
      t_xx_ff   <= t_xx_in;
      t_yy_ff   <= t_yy_in;
      t_zz_ff   <= t_zz_in;
      t_xy_ff   <= t_xy_in;
      t_xz_ff   <= t_xz_in;
      t_yz_ff   <= t_yz_in;
      bb_c_ff   <= bb_c_in;
      bb_d_ff   <= bb_c_ff;
      s_diag_ff <= s_diag_in;
      s_off_ff  <= s_off_in;
   end

   assign cell_out = cell_ff;

endmodule

FILE: hdl/bdl_sqrt_cell.sv
module bdl_sqrt_cell import bdl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bdl_cell_type cell_in,
   output bdl_cell_type cell_out
);

   localparam int CUR_W = REM_W + 2;

   logic [CUR_W-1:0] cur;
   logic [CUR_W-1:0] trial;
   logic             take;
   bdl_cell_type     slot_ff, slot_in;

   // one restoring step: bring down two radicand bits, try root*4+1
   always_comb begin
      cur   = {cell_in.rem, cell_in.rad[RAD_W-1 -: 2]};
      trial = CUR_W'({cell_in.root, 2'b01});
      take  = (cur >= trial);
      slot_in.valid   = cell_in.valid;
      slot_in.invalid = cell_in.invalid;
      slot_in.rad     = {cell_in.rad[RAD_W-3:0], 2'b00};
      slot_in.rem     = take ? REM_W'(cur - trial) : cur[REM_W-1:0];
      slot_in.root    = {cell_in.root[ROOT_W-2:0], take};
   end

   // advance the slot to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign cell_out = slot_ff;

endmodule

FILE: hdl/bdl_out_fifo.sv
module bdl_out_fifo import bdl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  bdl_rsp_type wr_data,
   input  logic        rd_en,
   output logic        rd_valid,
   output bdl_rsp_type rd_data
);

   bdl_rsp_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    do_rd;

   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(wr_en) - FIFO_CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // the credit count upstream must keep the queue from overflowing
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff != FIFO_CNT_W'(FIFO_DEPTH)) || do_rd)
      else $error("output queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("output queue pointers disagree when empty");

endmodule

FILE: hdl/bond_deformed_length.sv
// Deformed bond length under a homogeneous Green strain.
//
// req_bus carries one bond vector (bond_x, bond_y, bond_z, signed Q3.12) per
// beat; rsp_bus returns one beat per request, in order, with deformed_length
// (unsigned Q4.12, rounded, saturating) and invalid (form not positive).
// The six strain registers and planar_mode are written through csr_we /
// csr_index / csr_wdata; write them only while no request is in flight.
// Writes to index 7 are dropped.
//
// Five product and sum stages feed a chain of 20 square-root cells, one
// result bit per cell. The block takes one beat per cycle while
// req_bus.ready is high. A 32-entry output queue holds finished results;
// a credit count of beats in flight keeps req_bus.ready high until 32
// results are owed, so a stalled receiver holds nothing back until then,
// and the queue can always take every owed result.
// Reset (synchronous) clears the registers to zero and empties the pipe and
// the queue.
module bond_deformed_length import bdl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   bdl_req_if.sink                req_bus,
   bdl_rsp_if.source              rsp_bus
);

   bdl_strain_type          strain_ff, strain_in;
   bdl_strain_type          strain_eff;
   logic                    planar_ff, planar_in;
   logic [FIFO_CNT_W-1:0]   inflight_ff, inflight_in;
   logic                    req_beat;
   logic                    rsp_beat;
   bdl_cell_type            chain [SQRT_STEPS+1];
   bdl_cell_type            last;
   logic [ROOT_W:0]         root_inc;
   logic [ROOT_W-1:0]       half;
   bdl_rsp_type             rsp_word;
   bdl_rsp_type             rd_word;
   logic                    rd_valid;

   // register writes
   always_comb begin
      strain_in = strain_ff;
      planar_in = planar_ff;
      if (csr_we) begin
         case (csr_index)
            REG_STRAIN_XX: strain_in.xx = csr_wdata;
            REG_STRAIN_YY: strain_in.yy = csr_wdata;
            REG_STRAIN_ZZ: strain_in.zz = csr_wdata;
            REG_STRAIN_YZ: strain_in.yz = csr_wdata;
            REG_STRAIN_XZ: strain_in.xz = csr_wdata;
            REG_STRAIN_XY: strain_in.xy = csr_wdata;
            REG_PLANAR:    planar_in    = csr_wdata[0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strain_ff <= '0;
         planar_ff <= 1'b0;
      end else begin
         strain_ff <= strain_in;
         planar_ff <= planar_in;
      end
   end

   // drop the z-related terms in planar mode
   always_comb begin
      strain_eff = strain_ff;
      if (planar_ff) begin
         strain_eff.zz = '0;
         strain_eff.yz = '0;
         strain_eff.xz = '0;
      end
   end

   // credit: one per beat accepted and not yet delivered
   assign req_bus.ready = (inflight_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign rsp_beat      = rsp_bus.valid && rsp_bus.ready;
   assign inflight_in   = inflight_ff + FIFO_CNT_W'(req_beat) - FIFO_CNT_W'(rsp_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   bdl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_beat),
      .bond_x   (req_bus.bond_x),
      .bond_y   (req_bus.bond_y),
      .bond_z   (req_bus.bond_z),
      .strain   (strain_eff),
      .cell_out (chain[0])
   );

   // square-root chain, one result bit per cell
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
      bdl_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[k]),
         .cell_out (chain[k+1])
      );
   end

   // round half up, then saturate to the output width
   always_comb begin
      last     = chain[SQRT_STEPS];
      root_inc = {1'b0, last.root} + 1'b1;
      half     = root_inc[ROOT_W:1];
      rsp_word.deformed_length = (half[ROOT_W-1:LEN_W] != '0) ? {LEN_W{1'b1}}
                                                                : half[LEN_W-1:0];
      rsp_word.invalid = last.invalid;
   end

   bdl_out_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (last.valid),
      .wr_data  (rsp_word),
      .rd_en    (rsp_bus.ready),
      .rd_valid (rd_valid),
      .rd_data  (rd_word)
   );

   assign rsp_bus.valid           = rd_valid;
   assign rsp_bus.deformed_length = rd_word.deformed_length;
   assign rsp_bus.invalid         = rd_word.invalid;

   assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("more beats in flight than the queue can hold");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (inflight_ff != '0))
      else $error("result present with no beat owed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.invalid |-> (rsp_bus.deformed_length == '0))
      else $error("invalid result carries a nonzero length");

endmodule

FILE: tb/bond_deformed_length_tb.sv
module bond_deformed_length_tb import bdl_pkg::*;;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 6;
   localparam int PIPE_LATENCY  = 25;
   localparam int ROOT_SHIFT    = 11;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_BONDS   = 250;
   localparam int MAX_REPORTS   = 10;
   localparam int WATCHDOG      = 4_000_000;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;

   typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_BLOCKS} rx_mode_e;

   // Shadow of the strain registers plus the lengths still owed by the block.
   class length_board;
      bdl_strain_type strain;
      logic           planar;
      bdl_rsp_type    owed_lengths[$];
      int             mismatches;
      int             failures;

      function new();
         strain     = '0;
         planar     = 1'b0;
         mismatches = 0;
         failures   = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index,
                                 logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_STRAIN_XX: strain.xx = data;
            REG_STRAIN_YY: strain.yy = data;
            REG_STRAIN_ZZ: strain.zz = data;
            REG_STRAIN_YZ: strain.yz = data;
            REG_STRAIN_XZ: strain.xz = data;
            REG_STRAIN_XY: strain.xy = data;
            REG_PLANAR:    planar    = data[0];
            default: ;
         endcase
      endfunction

      // Length of b under C = I + 2E, rounded half up, saturating.
      function bdl_rsp_type predict_length(logic signed [BOND_W-1:0] bx,
                                           logic signed [BOND_W-1:0] by,
                                           logic signed [BOND_W-1:0] bz);
         longint      x, y, z, exx, eyy, ezz, eyz, exz, exy, bb, form;
         logic [63:0] rad, root, trial, len;
         int          i;
         bdl_rsp_type rsp;
         x   = longint'(bx);
         y   = longint'(by);
         z   = longint'(bz);
         exx = longint'($signed(strain.xx));
         eyy = longint'($signed(strain.yy));
         ezz = longint'($signed(strain.zz));
         eyz = longint'($signed(strain.yz));
         exz = longint'($signed(strain.xz));
         exy = longint'($signed(strain.xy));
         // planar: drop the z strain terms, the z identity term stays
         if (planar) begin
            ezz = 0;
            eyz = 0;
            exz = 0;
         end
         bb   = x * x + y * y + z * z;
         form = 8192 * bb + 2 * (exx * x * x + eyy * y * y + ezz * z * z
                + 2 * exy * x * y + 2 * exz * x * z + 2 * eyz * y * z);
         if (form <= 0) begin
            rsp.deformed_length = '0;
            rsp.invalid         = 1'b1;
            return rsp;
         end
         rad  = form;
         rad  = rad >> ROOT_SHIFT;
         root = 0;
         // build the root bit by bit, radicand stays below 2^40
         for (i = 25; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= rad)
               root = trial;
         end
         len = (root + 1) >> 1;
         if (len > 64'hFFFF)
            len = 64'hFFFF;
         rsp.deformed_length = len[LEN_W-1:0];
         rsp.invalid         = 1'b0;
         return rsp;
      endfunction

      function void note_bond(logic signed [BOND_W-1:0] bx,
                              logic signed [BOND_W-1:0] by,
                              logic signed [BOND_W-1:0] bz);
         owed_lengths.push_back(predict_length(bx, by, bz));
      endfunction

      function void check_length(logic [LEN_W-1:0] length, logic invalid);
         bdl_rsp_type want;
         if (owed_lengths.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result beat: length %0d invalid %0b", length, invalid);
            return;
         end
         want = owed_lengths.pop_front();
         if (want.deformed_length !== length || want.invalid !== invalid) begin
            failures++;
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result mismatch: expected length %0d invalid %0b, got length %0d invalid %0b",
                        want.deformed_length, want.invalid, length, invalid);
         end
      endfunction

      function int pending();
         return owed_lengths.size();
      endfunction

      function int close_out();
         if (owed_lengths.size() != 0) begin
            $display("%0d result beats never arrived", owed_lengths.size());
            failures += owed_lengths.size();
         end
         return failures;
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bdl_req_if req_bus();
   bdl_rsp_if rsp_bus();

   length_board board;
   int          burst_left;
   int          gap_len;

   bond_deformed_length dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Check every result beat against the oldest owed length.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         board.check_length(rsp_bus.deformed_length, rsp_bus.invalid);
   end

   // Receiver: switch between stall patterns in windows of random length.
   initial begin
      rx_mode_e mode;
      int       window;
      int       hold;
      hold          = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         mode   = rx_mode_e'($urandom_range(0, 3));
         window = $urandom_range(20, 200);
         repeat (window) begin
            @(negedge clock);
            case (mode)
               RX_OPEN:   rsp_bus.ready = 1'b1;
               RX_MOSTLY: rsp_bus.ready = ($urandom_range(0, 3) != 0);
               RX_SPARSE: rsp_bus.ready = ($urandom_range(0, 3) == 0);
               default: begin
                  if (hold > 0) begin
                     rsp_bus.ready = 1'b0;
                     hold--;
                  end else begin
                     rsp_bus.ready = 1'b1;
                     if ($urandom_range(0, 2) == 0)
                        hold = $urandom_range(5, 30);
                  end
               end
            endcase
         end
      end
   end

   initial begin
      #WATCHDOG;
      $display("[bond_deformed_length] ERROR");
      $finish;
   end

   task automatic pick_burst();
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      board.set_register(index, data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_strain(input logic [15:0] xx, input logic [15:0] yy,
                              input logic [15:0] zz, input logic [15:0] yz,
                              input logic [15:0] xz, input logic [15:0] xy,
                              input logic [15:0] planar_word);
      write_register(REG_STRAIN_XX, xx);
      write_register(REG_STRAIN_YY, yy);
      write_register(REG_STRAIN_ZZ, zz);
      write_register(REG_STRAIN_YZ, yz);
      write_register(REG_STRAIN_XZ, xz);
      write_register(REG_STRAIN_XY, xy);
      write_register(REG_PLANAR, planar_word);
   endtask

   // Present one bond beat and hold it until accepted; gap at burst end.
   task automatic send_bond(input logic signed [BOND_W-1:0] bx,
                            input logic signed [BOND_W-1:0] by,
                            input logic signed [BOND_W-1:0] bz);
      @(negedge clock);
      req_bus.valid  = 1'b1;
      req_bus.bond_x = bx;
      req_bus.bond_y = by;
      req_bus.bond_z = bz;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.note_bond(bx, by, bz);
      burst_left--;
      if (burst_left <= 0) begin
         pick_burst();
         if (gap_len > 0) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
            repeat (gap_len - 1) @(negedge clock);
         end
      end
   endtask

   // Drop valid and wait until every owed length is back.
   task automatic settle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] random_strain();
      case ($urandom_range(0, 3))
         0:       return 16'd0;
         1:       return 16'($urandom_range(0, 4095) - 2048);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_bond(output logic signed [BOND_W-1:0] bx,
                              output logic signed [BOND_W-1:0] by,
                              output logic signed [BOND_W-1:0] bz);
      case ($urandom_range(0, 3))
         0, 1: begin
            bx = BOND_W'($urandom);
            by = BOND_W'($urandom);
            bz = BOND_W'($urandom);
         end
         2: begin
            // near unit length, where most real bonds sit
            bx = BOND_W'($urandom_range(0, 8191) - 4096);
            by = BOND_W'($urandom_range(0, 8191) - 4096);
            bz = BOND_W'($urandom_range(0, 8191) - 4096);
         end
         default: begin
            bx = '0;
            by = '0;
            bz = '0;
            case ($urandom_range(0, 2))
               0:       bx = BOND_W'($urandom);
               1:       by = BOND_W'($urandom);
               default: bz = BOND_W'($urandom);
            endcase
         end
      endcase
   endtask

   initial begin
      logic signed [BOND_W-1:0] bx, by, bz;
      int                       phase;
      board          = new();
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = REG_STRAIN_XX;
      csr_wdata      = '0;
      req_bus.valid  = 1'b0;
      req_bus.bond_x = '0;
      req_bus.bond_y = '0;
      req_bus.bond_z = '0;
      pick_burst();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero strain from reset: zero vector is invalid, extremes stay in range
      send_bond(16'h0000, 16'h0000, 16'h0000);
      send_bond(16'h0001, 16'h0000, 16'h0000);
      send_bond(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_bond(16'h8000, 16'h8000, 16'h8000);
      send_bond(16'h7FFF, 16'h8000, 16'h0000);
      send_bond(16'h0000, 16'h0000, 16'h8000);
      send_bond(16'hFFFF, 16'hFFFF, 16'hFFFF);
      settle();

      // tiny positive form rounds to zero length without invalid
      load_strain(16'hF001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_bond(16'h0001, 16'h0000, 16'h0000);
      send_bond(16'h0002, 16'h0000, 16'h0000);
      settle();

      // largest strain: saturate the length
      load_strain(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
      send_bond(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_bond(16'h8000, 16'h7FFF, 16'h8000);
      send_bond(16'h0100, 16'h0000, 16'h0000);
      settle();

      // most negative strain: form goes negative
      load_strain(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000);
      send_bond(16'h7FFF, 16'h0000, 16'h0000);
      send_bond(16'h0000, 16'h0000, 16'h1000);
      send_bond(16'h0001, 16'h0001, 16'h0001);
      settle();

      // planar on through a wide write, z keeps only its identity term
      write_register(REG_PLANAR, 16'hFFFF);
      send_bond(16'h0000, 16'h0000, 16'h1000);
      send_bond(16'h1000, 16'h0000, 16'h0000);
      settle();
      // unused index is dropped; only bit 0 of planar is kept
      write_register(REG_UNUSED, 16'h7FFF);
      write_register(REG_PLANAR, 16'hFFFE);
      send_bond(16'h0000, 16'h0000, 16'h1000);
      settle();

      // exact values: stretch along x and shear in xy
      load_strain(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0800, 16'h0000);
      send_bond(16'h1000, 16'h0000, 16'h0000);
      send_bond(16'h1000, 16'h1000, 16'h0000);
      settle();

      // random strain settings, each one with a stream of random bonds
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_strain(random_strain(), random_strain(), random_strain(), random_strain(),
                     random_strain(), random_strain(), 16'($urandom));
         if ($urandom_range(0, 2) == 0)
            write_register(REG_UNUSED, CSR_DATA_W'($urandom));
         repeat (PHASE_BONDS) begin
            random_bond(bx, by, bz);
            send_bond(bx, by, bz);
         end
         settle();
      end

      if (board.close_out() == 0)
         $display("[bond_deformed_length] OK");
      else
         $display("[bond_deformed_length] ERROR");
      $finish;
   end

endmodule
